@@ sv/mtt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the multi-timer table engine.
// Used by mtt_ctrl, mtt_dpath and multi_timer_table_engine; no dependencies.

package mtt_pkg;

    // Field widths fixed by the interface
    localparam int FUNC_W = 2;
    localparam int MS_W   = 32;
    localparam int TASK_W = 8;
    localparam int SIG_W  = 32;
    localparam int KIND_W = 2;

    // Default table size and per-item result limit
    localparam int DEF_SLOTS   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_FIRED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH,
        S_START
    } t_state;

    // One timer entry as stored in the table memory
    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [SIG_W-1:0]  sig;
        logic [MS_W-1:0]   rem;
        logic [MS_W-1:0]   period;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch the accepted item, arm the walk
        logic walk_en;    // run the table walk this cycle
        logic walk_end;   // commit survivor count
        logic start_put;  // insert new timer and answer it / report table full
        logic flush;      // move the held fired result out as the last one
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_free;
        logic pend_vld;
    } t_status;

endpackage

@@ sv/mtt_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing state machine of the multi-timer table engine.
// Depends on mtt_pkg for the state type and command/status structs.

module mtt_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [mtt_pkg::FUNC_W-1:0] i_func,
    input  mtt_pkg::t_status          i_status,
    output logic                      o_ready,
    output mtt_pkg::t_cmd             o_cmd
);
    import mtt_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_func == FUNC_TICK || i_func == FUNC_CANCEL) begin
                        n_state = S_WALK;
                    end else if (i_func == FUNC_START) begin
                        n_state = S_START;
                    end
                end
            end
            S_WALK: begin
                o_cmd.walk_en = 1'b1;
                if (i_status.walk_done) begin
                    o_cmd.walk_end = 1'b1;
                    n_state        = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // hand out the held fired result, flagged last
                if (!i_status.pend_vld) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_START: begin
                if (i_status.out_free) begin
                    o_cmd.start_put = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/mtt_dpath.sv @@
`timescale 1ns / 1ps
// Datapath: age-ordered timer memory (ring, newest at head), walk pointers,
// held fired result and output register. Depends on mtt_pkg.

module mtt_dpath #(
    parameter int SLOTS = mtt_pkg::DEF_SLOTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mtt_pkg::t_cmd              i_cmd,
    output mtt_pkg::t_status           o_status,
    input  logic [mtt_pkg::FUNC_W-1:0] i_func,
    input  logic [mtt_pkg::MS_W-1:0]   i_elapsed_ms,
    input  logic [mtt_pkg::TASK_W-1:0] i_task_id,
    input  logic [mtt_pkg::SIG_W-1:0]  i_signal_mask,
    input  logic [mtt_pkg::MS_W-1:0]   i_delay_ms,
    input  logic [mtt_pkg::MS_W-1:0]   i_period_ms,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [mtt_pkg::KIND_W-1:0] o_kind,
    output logic [mtt_pkg::TASK_W-1:0] o_out_task,
    output logic [mtt_pkg::SIG_W-1:0]  o_out_signal,
    output logic                       o_last
);
    import mtt_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // Table memory, position = age order from head
    t_entry r_mem [SLOTS];
    t_entry r_rd_data;

    // Latched item
    logic [FUNC_W-1:0] r_op;
    logic [MS_W-1:0]   r_elapsed;
    logic [TASK_W-1:0] r_task;
    logic [SIG_W-1:0]  r_sig;
    logic [MS_W-1:0]   r_delay;
    logic [MS_W-1:0]   r_period;

    // Ring and walk pointers
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_keep;
    logic [IW-1:0] r_rd_addr;
    logic [IW-1:0] r_wr_addr;
    logic          r_rd_vld;

    // Held fired result (its last flag is known only later)
    logic              r_pend_vld;
    logic [TASK_W-1:0] r_pend_task;
    logic [SIG_W-1:0]  r_pend_sig;
    logic [NRES_W-1:0] r_nres;

    // Output register
    logic              r_out_vld;
    logic [KIND_W-1:0] r_out_kind;
    logic [TASK_W-1:0] r_out_task;
    logic [SIG_W-1:0]  r_out_sig;
    logic              r_out_last;

    logic          out_free;
    logic          is_tick;
    logic          fire;
    logic          match;
    logic          keep;
    logic          emit;
    logic          stall;
    logic          adv;
    logic          proc;
    logic          rd_go;
    logic          full;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] rd_inc;
    logic [IW-1:0] wr_inc;
    t_entry        upd;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    t_entry        mem_wd;

    // Ring pointer arithmetic
    assign head_dec = (r_head == '0) ? IW'(SLOTS - 1) : r_head - 1'b1;
    assign rd_inc   = (r_rd_addr == IW'(SLOTS - 1)) ? '0 : r_rd_addr + 1'b1;
    assign wr_inc   = (r_wr_addr == IW'(SLOTS - 1)) ? '0 : r_wr_addr + 1'b1;
    assign full     = (r_count == CW'(SLOTS));

    // Per-entry evaluation of the entry held in the registered read data
    assign out_free = !r_out_vld || i_out_ready;
    assign is_tick  = (r_op == FUNC_TICK);
    assign fire     = is_tick && (r_elapsed >= r_rd_data.rem);
    assign match    = (r_rd_data.task_id == r_task) && (r_rd_data.sig == r_sig);
    assign keep     = is_tick ? (!fire || r_rd_data.period != '0) : !match;
    assign emit     = fire && (r_nres < NRES_W'(MAX_RESULTS));
    assign stall    = r_rd_vld && emit && r_pend_vld && !out_free;
    assign adv      = i_cmd.walk_en && !stall;
    assign proc     = adv && r_rd_vld;
    assign rd_go    = adv && (r_idx < r_count);

    always_comb begin
        upd = r_rd_data;
        if (is_tick) begin
            upd.rem = fire ? r_rd_data.period : r_rd_data.rem - r_elapsed;
        end
    end

    // Memory write port: compaction write or new timer at head
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wr_addr;
        mem_wd = upd;
        if (i_cmd.start_put && !full) begin
            mem_we = 1'b1;
            mem_wa = head_dec;
            mem_wd = '{task_id: r_task, sig: r_sig, rem: r_delay, period: r_period};
        end else if (proc && keep) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (rd_go) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    // Latched item fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_func;
            r_elapsed <= i_elapsed_ms;
            r_task    <= i_task_id;
            r_sig     <= i_signal_mask;
            r_delay   <= i_delay_ms;
            r_period  <= i_period_ms;
        end
    end

    // Ring occupancy and walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_keep     <= '0;
            r_rd_addr  <= '0;
            r_wr_addr  <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_nres     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx      <= '0;
                r_keep     <= '0;
                r_rd_addr  <= r_head;
                r_wr_addr  <= r_head;
                r_rd_vld   <= 1'b0;
                r_pend_vld <= 1'b0;
                r_nres     <= '0;
            end
            if (adv) begin
                r_rd_vld <= rd_go;
            end
            if (rd_go) begin
                r_rd_addr <= rd_inc;
                r_idx     <= r_idx + 1'b1;
            end
            if (proc && keep) begin
                r_wr_addr <= wr_inc;
                r_keep    <= r_keep + 1'b1;
            end
            if (proc && emit) begin
                r_pend_vld <= 1'b1;
                r_nres     <= r_nres + 1'b1;
            end
            if (i_cmd.flush) begin
                r_pend_vld <= 1'b0;
            end
            if (i_cmd.walk_end) begin
                r_count <= r_keep;
            end
            if (i_cmd.start_put && !full) begin
                r_head  <= head_dec;
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Held fired result payload
    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_pend_task <= r_rd_data.task_id;
            r_pend_sig  <= r_rd_data.sig;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.start_put || i_cmd.flush || (proc && emit && r_pend_vld)) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_put) begin
            r_out_kind <= full ? KIND_FULL : KIND_CLEAR;
            r_out_task <= r_task;
            r_out_sig  <= r_sig;
            r_out_last <= 1'b1;
        end else if (i_cmd.flush || (proc && emit && r_pend_vld)) begin
            r_out_kind <= KIND_FIRED;
            r_out_task <= r_pend_task;
            r_out_sig  <= r_pend_sig;
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_status.walk_done = (r_idx == r_count) && !r_rd_vld;
    assign o_status.out_free  = out_free;
    assign o_status.pend_vld  = r_pend_vld;

    assign o_out_valid  = r_out_vld;
    assign o_kind       = r_out_kind;
    assign o_out_task   = r_out_task;
    assign o_out_signal = r_out_sig;
    assign o_last       = r_out_last;

endmodule

@@ sv/multi_timer_table_engine.sv @@
`timescale 1ns / 1ps
// Top level of the multi-timer table engine: controller plus datapath.
// Depends on mtt_pkg, mtt_ctrl and mtt_dpath.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | i_valid / o_ready   | i_func i_elapsed_ms i_task_id i_signal_mask
//          |                     | i_delay_ms i_period_ms
//  out     | o_valid / i_ready   | o_kind o_out_task o_out_signal o_last
//
// One item at a time. Start: accept, then insert once the output
// register is free. Tick and cancel walk the timers newest first through the
// single-port read of the table memory, one timer per cycle while the output
// side does not stall fired items.
// Reset (synchronous, active low) empties the table at once; no clearing pass.
// A new item is taken while the last result still sits in the output register.

module multi_timer_table_engine #(
    parameter int SLOTS = mtt_pkg::DEF_SLOTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mtt_pkg::FUNC_W-1:0] i_func,
    input  logic [mtt_pkg::MS_W-1:0]   i_elapsed_ms,
    input  logic [mtt_pkg::TASK_W-1:0] i_task_id,
    input  logic [mtt_pkg::SIG_W-1:0]  i_signal_mask,
    input  logic [mtt_pkg::MS_W-1:0]   i_delay_ms,
    input  logic [mtt_pkg::MS_W-1:0]   i_period_ms,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mtt_pkg::KIND_W-1:0] o_kind,
    output logic [mtt_pkg::TASK_W-1:0] o_out_task,
    output logic [mtt_pkg::SIG_W-1:0]  o_out_signal,
    output logic                       o_last
);
    import mtt_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer
    mtt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    // Timer table and result path
    mtt_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_func        (i_func),
        .i_elapsed_ms  (i_elapsed_ms),
        .i_task_id     (i_task_id),
        .i_signal_mask (i_signal_mask),
        .i_delay_ms    (i_delay_ms),
        .i_period_ms   (i_period_ms),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_kind        (o_kind),
        .o_out_task    (o_out_task),
        .o_out_signal  (o_out_signal),
        .o_last        (o_last)
    );

    // Start answers are always a single result
    a_start_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != KIND_FIRED) |-> o_last)
        else $error("start result without last flag");

    // A held result is never overwritten by a start answer
    a_start_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start_put |-> status.out_free)
        else $error("start answer into a busy output register");

    // Flush only moves a result that is actually held
    a_flush_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.flush |-> (status.pend_vld && status.out_free))
        else $error("flush without a held fired result");

    // No walk step follows the walk end, so the walk completes before the last fired result leaves
    a_end_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_end |=> !cmd.walk_en)
        else $error("walk continues after its end");

endmodule
